// ----- rtl/ledd_pkg.sv -----
// ============================================================================
// ledd_pkg: shared types and constants of the LED dimmer channel
// Request codes, effect codes, register indexes, serial unit widths and the
// speed-to-period tables.
// ============================================================================
package ledd_pkg;

  // request codes carried by one input beat
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ON   = 2'd1,
    REQ_OFF  = 2'd2,
    REQ_NEXT = 2'd3
  } req_t;

  // effect codes
  localparam logic [2:0] SCH_STATIC = 3'd0;
  localparam logic [2:0] SCH_WAKE   = 3'd1;
  localparam logic [2:0] SCH_PULSE  = 3'd2;
  localparam logic [2:0] SCH_RAMP   = 3'd3;
  localparam logic [2:0] SCH_CANDLE = 3'd4;
  localparam logic [2:0] SCH_LAST   = SCH_CANDLE;

  // configuration register indexes
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_SPEED      = 1'b1;

  localparam logic [7:0]  CANDLE_FLOOR   = 8'd190;
  localparam logic [31:0] CANDLE_TICK_MS = 32'd40;
  localparam logic [7:0]  CANDLE_RESET   = 8'd220;
  localparam logic [7:0]  LEVEL_MAX      = 8'd255;
  localparam logic [16:0] Q15_ONE        = 17'd32768;
  localparam logic [63:0] PI_Q30         = 64'd3373259426;

  // serial divider: 32-bit dividend, 16-bit divisor
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;
  typedef logic [DIV_NW-1:0] div_num_t;
  typedef logic [DIV_DW-1:0] div_den_t;

  // serial multiplier: Q1.15 ease value (with 1.0) times an 8-bit level
  localparam int MUL_AW = 17;
  localparam int MUL_BW = 8;
  typedef logic [MUL_AW-1:0]        mul_a_t;
  typedef logic [MUL_BW-1:0]        mul_b_t;
  typedef logic [MUL_AW+MUL_BW-1:0] mul_p_t;

  // pulse half period in ms; speed clamped to 1..20
  function automatic logic [11:0] pulse_half(input logic [4:0] spd);
    logic [11:0] h;
    case (spd)
      5'd0, 5'd1: h = 12'd4000;
      5'd2:       h = 12'd3832;
      5'd3:       h = 12'd3664;
      5'd4:       h = 12'd3495;
      5'd5:       h = 12'd3327;
      5'd6:       h = 12'd3158;
      5'd7:       h = 12'd2990;
      5'd8:       h = 12'd2822;
      5'd9:       h = 12'd2653;
      5'd10:      h = 12'd2485;
      5'd11:      h = 12'd2316;
      5'd12:      h = 12'd2148;
      5'd13:      h = 12'd1979;
      5'd14:      h = 12'd1811;
      5'd15:      h = 12'd1643;
      5'd16:      h = 12'd1474;
      5'd17:      h = 12'd1306;
      5'd18:      h = 12'd1137;
      5'd19:      h = 12'd969;
      default:    h = 12'd800;
    endcase
    return h;
  endfunction

  // random ramp interval in ms; speed clamped to 1..20
  function automatic logic [11:0] rand_interval(input logic [4:0] spd);
    logic [11:0] v;
    case (spd)
      5'd0, 5'd1: v = 12'd2500;
      5'd2:       v = 12'd2390;
      5'd3:       v = 12'd2279;
      5'd4:       v = 12'd2169;
      5'd5:       v = 12'd2058;
      5'd6:       v = 12'd1948;
      5'd7:       v = 12'd1837;
      5'd8:       v = 12'd1727;
      5'd9:       v = 12'd1616;
      5'd10:      v = 12'd1506;
      5'd11:      v = 12'd1395;
      5'd12:      v = 12'd1285;
      5'd13:      v = 12'd1174;
      5'd14:      v = 12'd1064;
      5'd15:      v = 12'd953;
      5'd16:      v = 12'd843;
      5'd17:      v = 12'd732;
      5'd18:      v = 12'd622;
      5'd19:      v = 12'd511;
      default:    v = 12'd400;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/led_effect_dimmer_channel_unit.sv -----
// ============================================================================
// led_effect_dimmer_channel_unit: one LED dimmer channel
// Renders an 8-bit duty per tick from static, wake-up, pulse, random ramp or
// candle effect, with an eased fade-out on power-off from wake-up.
// ============================================================================
// One input beat is taken at a time; in_ready is high only while the channel
// waits for a request. A tick that renders static goes straight to the output
// stage; fade-out and wake-up run a serial divide for the ease index, one ease
// table read and a serial multiply; pulse first adds a serial modulo; ramp and
// candle run a serial multiply, then a serial divide by 255. One bit-serial
// divider is shared by all of these jobs. The finished duty sits in an output
// register, so the next request is accepted while that beat waits on out_ready.
// ============================================================================
module led_effect_dimmer_channel_unit #(
  parameter int FADE_TIME_MS = 4000,
  parameter int EASE_STEPS   = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_rand_target,
  input  logic [6:0]  in_rand_candle,
  input  logic [5:0]  in_rand_flicker,
  // duty channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_duty,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ledd_pkg::*;

  localparam int SW = $clog2(EASE_STEPS + 1);
  localparam logic [31:0] FADE_MS   = 32'(FADE_TIME_MS);
  localparam div_den_t    FADE_DEN  = div_den_t'(FADE_TIME_MS);
  localparam div_num_t    EASE_MUL  = div_num_t'(EASE_STEPS);
  localparam div_num_t    EASE_LAST = div_num_t'(EASE_STEPS);

  typedef logic [15:0] ease_tab_t [0:EASE_STEPS];

  // ease curve e[k] = 32768 * (0.5 - 0.5*cos(pi*k/N)) as sin^2, Q30 series
  function automatic ease_tab_t build_ease();
    ease_tab_t          tab;
    logic [63:0]        x, x2, term, sq;
    logic signed [63:0] s;
    for (int k = 0; k <= EASE_STEPS; k++) begin
      x    = (PI_Q30 * 64'(k)) / 64'(2 * EASE_STEPS);
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) s = s - $signed(term);
        else s = s + $signed(term);
      end
      if (s < 0) s = 0;
      sq = $unsigned(s) * $unsigned(s);
      sq = (sq + (64'd1 << 44)) >> 45;
      if (sq > 64'd32768) sq = 64'd32768;
      tab[k] = 16'(sq);
    end
    return tab;
  endfunction

  localparam ease_tab_t EASE_TAB = build_ease();

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EVAL  = 8'b0000_0010,
    ST_MOD   = 8'b0000_0100,
    ST_IDX   = 8'b0000_1000,
    ST_ROM   = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_SCALE = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    JOB_FADE  = 2'd0,
    JOB_EASE  = 2'd1,
    JOB_SCALE = 2'd2
  } job_t;

  state_t      state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic        power_on_r, power_on_nxt;
  logic [2:0]  scheme_r, scheme_nxt;
  logic        started_r, started_nxt;
  logic [31:0] anim_start_r, anim_start_nxt;
  logic [7:0]  last_level_r, last_level_nxt;
  logic        fading_r, fading_nxt;
  logic [31:0] fade_start_r, fade_start_nxt;
  logic [7:0]  fade_from_r, fade_from_nxt;
  logic [7:0]  ramp_level_r, ramp_level_nxt;
  logic [7:0]  ramp_target_r, ramp_target_nxt;
  logic [31:0] step_time_r, step_time_nxt;
  logic [7:0]  candle_base_r, candle_base_nxt;
  logic [11:0] half_r, half_nxt;
  logic [7:0]  res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_duty_r, out_duty_nxt;
  logic [7:0]  brightness_r;
  logic [4:0]  speed_r;

  // request beat held while it is worked on
  logic [1:0]  req_r;
  logic [31:0] now_r;
  logic [7:0]  rt_r;
  logic [6:0]  rc_r;
  logic [5:0]  rf_r;

  logic        div_start, div_done;
  div_num_t    div_dividend, div_quo;
  div_den_t    div_divisor, div_rem;
  logic        mul_start, mul_done;
  mul_a_t      mul_a;
  mul_b_t      mul_b;
  mul_p_t      mul_p;

  logic [15:0] ease_q_r;
  logic [SW-1:0] ease_idx;

  logic [31:0] anim_base, anim_el, fade_el, step_el;
  logic        fade_over, wake_over;
  logic [11:0] pulse_half_w, interval_w;
  logic [15:0] half2, half16, tri_num;
  logic        ramp_due, candle_due;
  logic [7:0]  ramp_tgt, ramp_new;
  logic [8:0]  candle_sum;
  logic [7:0]  candle_cur, flick;
  logic        cfg_wr;

  ledd_serial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ledd_serial_mul u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mul_start),
    .multiplicand (mul_a),
    .multiplier   (mul_b),
    .done         (mul_done),
    .product      (mul_p)
  );

  // elapsed times, all modulo 2^32
  assign anim_base = started_r ? anim_start_r : now_r;
  assign anim_el   = now_r - anim_base;
  assign fade_el   = now_r - fade_start_r;
  assign step_el   = now_r - step_time_r;
  assign fade_over = fade_el >= FADE_MS;
  assign wake_over = anim_el >= FADE_MS;

  assign pulse_half_w = pulse_half(speed_r);
  assign interval_w   = rand_interval(speed_r);

  // fold the pulse phase back over the half period
  assign half16  = 16'(half_r);
  assign half2   = {half16[14:0], 1'b0};
  assign tri_num = (div_rem <= half16) ? div_rem : half2 - div_rem;

  assign ramp_due = step_el >= 32'(interval_w);
  assign ramp_tgt = ramp_due ? rt_r : ramp_target_r;
  always_comb begin
    if (ramp_level_r < ramp_tgt) ramp_new = ramp_level_r + 8'd1;
    else if (ramp_level_r > ramp_tgt) ramp_new = ramp_level_r - 8'd1;
    else ramp_new = ramp_level_r;
  end

  assign candle_due = step_el >= CANDLE_TICK_MS;
  assign candle_sum = {1'b0, CANDLE_FLOOR} + 9'(rc_r);
  assign candle_cur = !candle_due ? candle_base_r :
                      (candle_sum[8] ? LEVEL_MAX : candle_sum[7:0]);
  assign flick      = (candle_cur >= 8'(rf_r)) ? candle_cur - 8'(rf_r) : 8'd0;

  // ease table index, clamped to the last entry
  assign ease_idx = (div_quo > EASE_LAST) ? SW'(EASE_STEPS) : div_quo[SW-1:0];

  always_ff @(posedge clk) begin
    ease_q_r <= EASE_TAB[ease_idx];
  end

  always_comb begin
    state_nxt       = state_r;
    job_nxt         = job_r;
    power_on_nxt    = power_on_r;
    scheme_nxt      = scheme_r;
    started_nxt     = started_r;
    anim_start_nxt  = anim_start_r;
    last_level_nxt  = last_level_r;
    fading_nxt      = fading_r;
    fade_start_nxt  = fade_start_r;
    fade_from_nxt   = fade_from_r;
    ramp_level_nxt  = ramp_level_r;
    ramp_target_nxt = ramp_target_r;
    step_time_nxt   = step_time_r;
    candle_base_nxt = candle_base_r;
    half_nxt        = half_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_duty_nxt    = out_duty_r;
    div_start       = 1'b0;
    div_dividend    = '0;
    div_divisor     = '0;
    mul_start       = 1'b0;
    mul_a           = '0;
    mul_b           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        state_nxt = ST_IDLE;
        case (req_t'(req_r))
          REQ_ON: begin
            power_on_nxt = 1'b1;
            started_nxt  = 1'b0;
            fading_nxt   = 1'b0;
          end
          REQ_OFF: begin
            power_on_nxt = 1'b0;
            if (scheme_r == SCH_WAKE && last_level_r != 8'd0) begin
              fading_nxt     = 1'b1;
              fade_start_nxt = now_r;
              fade_from_nxt  = last_level_r;
            end else begin
              last_level_nxt = 8'd0;
              res_nxt        = 8'd0;
              state_nxt      = ST_DONE;
            end
          end
          REQ_NEXT: begin
            scheme_nxt  = (scheme_r >= SCH_LAST) ? SCH_STATIC : scheme_r + 3'd1;
            started_nxt = 1'b0;
          end
          REQ_TICK: begin
            if (fading_r) begin
              if (fade_over) begin
                fading_nxt     = 1'b0;
                last_level_nxt = 8'd0;
                res_nxt        = 8'd0;
                state_nxt      = ST_DONE;
              end else begin
                div_start    = 1'b1;
                div_dividend = div_num_t'(fade_el[DIV_DW-1:0]) * EASE_MUL;
                div_divisor  = FADE_DEN;
                job_nxt      = JOB_FADE;
                state_nxt    = ST_IDX;
              end
            end else if (power_on_r) begin
              case (scheme_r)
                SCH_WAKE: begin
                  if (!started_r) begin
                    started_nxt    = 1'b1;
                    anim_start_nxt = now_r;
                  end
                  if (wake_over) begin
                    last_level_nxt = brightness_r;
                    res_nxt        = brightness_r;
                    state_nxt      = ST_DONE;
                  end else begin
                    div_start    = 1'b1;
                    div_dividend = div_num_t'(anim_el[DIV_DW-1:0]) * EASE_MUL;
                    div_divisor  = FADE_DEN;
                    job_nxt      = JOB_EASE;
                    state_nxt    = ST_IDX;
                  end
                end
                SCH_PULSE: begin
                  if (!started_r) begin
                    started_nxt    = 1'b1;
                    anim_start_nxt = now_r;
                  end
                  // phase within one full period
                  div_start    = 1'b1;
                  div_dividend = anim_el;
                  div_divisor  = {3'b000, pulse_half_w, 1'b0};
                  half_nxt     = pulse_half_w;
                  job_nxt      = JOB_EASE;
                  state_nxt    = ST_MOD;
                end
                SCH_RAMP: begin
                  if (ramp_due) begin
                    step_time_nxt   = now_r;
                    ramp_target_nxt = rt_r;
                  end
                  ramp_level_nxt = ramp_new;
                  mul_start      = 1'b1;
                  mul_a          = mul_a_t'(ramp_new);
                  mul_b          = brightness_r;
                  job_nxt        = JOB_SCALE;
                  state_nxt      = ST_MUL;
                end
                SCH_CANDLE: begin
                  if (candle_due) begin
                    step_time_nxt   = now_r;
                    candle_base_nxt = candle_cur;
                  end
                  mul_start = 1'b1;
                  mul_a     = mul_a_t'(flick);
                  mul_b     = brightness_r;
                  job_nxt   = JOB_SCALE;
                  state_nxt = ST_MUL;
                end
                default: begin
                  last_level_nxt = brightness_r;
                  res_nxt        = brightness_r;
                  state_nxt      = ST_DONE;
                end
              endcase
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_MOD: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_num_t'(tri_num) * EASE_MUL;
          div_divisor  = div_den_t'(half_r);
          state_nxt    = ST_IDX;
        end
      end

      ST_IDX: begin
        // table read lands in ease_q_r on the edge that leaves this state
        if (div_done) state_nxt = ST_ROM;
      end

      ST_ROM: begin
        mul_start = 1'b1;
        if (job_r == JOB_FADE) begin
          mul_a = Q15_ONE - mul_a_t'(ease_q_r);
          mul_b = fade_from_r;
        end else begin
          mul_a = mul_a_t'(ease_q_r);
          mul_b = brightness_r;
        end
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        if (mul_done) begin
          case (job_r)
            JOB_FADE: begin
              res_nxt   = mul_p[22:15];
              state_nxt = ST_DONE;
            end
            JOB_EASE: begin
              last_level_nxt = mul_p[22:15];
              res_nxt        = mul_p[22:15];
              state_nxt      = ST_DONE;
            end
            default: begin
              div_start    = 1'b1;
              div_dividend = div_num_t'(mul_p[15:0]);
              div_divisor  = div_den_t'(LEVEL_MAX);
              state_nxt    = ST_SCALE;
            end
          endcase
        end
      end

      ST_SCALE: begin
        if (div_done) begin
          last_level_nxt = div_quo[7:0];
          res_nxt        = div_quo[7:0];
          state_nxt      = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      job_r         <= JOB_FADE;
      power_on_r    <= 1'b0;
      scheme_r      <= SCH_STATIC;
      started_r     <= 1'b0;
      anim_start_r  <= '0;
      last_level_r  <= '0;
      fading_r      <= 1'b0;
      fade_start_r  <= '0;
      fade_from_r   <= '0;
      ramp_level_r  <= '0;
      ramp_target_r <= '0;
      step_time_r   <= '0;
      candle_base_r <= CANDLE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      job_r         <= job_nxt;
      power_on_r    <= power_on_nxt;
      scheme_r      <= scheme_nxt;
      started_r     <= started_nxt;
      anim_start_r  <= anim_start_nxt;
      last_level_r  <= last_level_nxt;
      fading_r      <= fading_nxt;
      fade_start_r  <= fade_start_nxt;
      fade_from_r   <= fade_from_nxt;
      ramp_level_r  <= ramp_level_nxt;
      ramp_target_r <= ramp_target_nxt;
      step_time_r   <= step_time_nxt;
      candle_base_r <= candle_base_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r     <= half_nxt;
    res_r      <= res_nxt;
    out_duty_r <= out_duty_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_req_type;
      now_r <= in_now_ms;
      rt_r  <= in_rand_target;
      rc_r  <= in_rand_candle;
      rf_r  <= in_rand_flicker;
    end
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= LEVEL_MAX;
      speed_r      <= 5'd10;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BRIGHTNESS: brightness_r <= pwdata[7:0];
        REG_SPEED:      speed_r      <= pwdata[4:0];
        default:        brightness_r <= brightness_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BRIGHTNESS: prdata = {24'd0, brightness_r};
      REG_SPEED:      prdata = {27'd0, speed_r};
      default:        prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;

endmodule

// ----- rtl/ledd_serial_div.sv -----
// ============================================================================
// ledd_serial_div: bit-serial restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ============================================================================
module ledd_serial_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ledd_pkg::div_num_t dividend,
  input  ledd_pkg::div_den_t divisor,
  output logic               done,
  output ledd_pkg::div_num_t quotient,
  output ledd_pkg::div_den_t remainder
);
  import ledd_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  div_num_t         q_r, q_nxt;
  div_den_t         rem_r, rem_nxt;
  div_den_t         den_r, den_nxt;
  logic [DIV_DW:0]  shifted;
  logic             fits;

  assign shifted = {rem_r, q_r[DIV_NW-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
      cnt_nxt = CNT_W'(DIV_NW);
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
      if (fits) begin
        rem_nxt = div_den_t'(shifted - {1'b0, den_r});
        q_nxt   = {q_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_DW-1:0];
        q_nxt   = {q_r[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/ledd_serial_mul.sv -----
// ============================================================================
// ledd_serial_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle; done pulses once the product holds.
// ============================================================================
module ledd_serial_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ledd_pkg::mul_a_t multiplicand,
  input  ledd_pkg::mul_b_t multiplier,
  output logic             done,
  output ledd_pkg::mul_p_t product
);
  import ledd_pkg::*;

  localparam int CNT_W = $clog2(MUL_BW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  mul_p_t           acc_r, acc_nxt;
  mul_p_t           a_r, a_nxt;
  mul_b_t           b_r, b_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      acc_nxt = '0;
      a_nxt   = mul_p_t'(multiplicand);
      b_nxt   = multiplier;
      cnt_nxt = CNT_W'(MUL_BW);
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt = {a_r[MUL_AW+MUL_BW-2:0], 1'b0};
      b_nxt = {1'b0, b_r[MUL_BW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
